### design/tfvw_pkg.sv
// shared constants, types and helpers for the terrain vertex warp block
`timescale 1ns / 1ps
`default_nettype none

package tfvw_pkg;

  localparam int GRID_SIDE    = 3;
  localparam int CORNER_COUNT = 4;
  localparam int GRID_CNT     = GRID_SIDE * GRID_SIDE;
  localparam int IDX_W        = 4;
  localparam int QW           = 32;
  // normalized coordinate, 0 to 1.0 in unsigned Q1.16
  localparam int CW           = 17;

  localparam int NDIV_STEPS = 16;
  localparam int LDIV_STEPS = 32;

  // stage numbers, stage 0 being the input register
  localparam int ST_CX    = 2 + NDIV_STEPS;
  localparam int SAMP_LAT = 7;
  localparam int ST_TZ    = ST_CX + SAMP_LAT;
  localparam int ST_ML    = 2 + LDIV_STEPS;
  localparam int ST_OUT   = ST_ML + 3;

  localparam logic signed [QW-1:0] EPS_RAW = 32'sd65;
  localparam logic [CW-1:0]        C_ONE   = 17'h10000;
  localparam logic signed [QW-1:0] Q_MAX   = 32'sh7fffffff;
  localparam logic signed [QW-1:0] Q_MIN   = 32'sh80000000;

  typedef enum logic {
    REQ_VERTEX = 1'b0,
    REQ_LOAD   = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    CFG_FOOT_MIN_X   = 3'd0,
    CFG_FOOT_MAX_X   = 3'd1,
    CFG_FOOT_MIN_Y   = 3'd2,
    CFG_FOOT_MAX_Y   = 3'd3,
    CFG_MODEL_SPAN   = 3'd4,
    CFG_TERRAIN_SPAN = 3'd5,
    CFG_CELL_SIZE    = 3'd6,
    CFG_BOUND_MIN_Z  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    logic [QW-1:0]    data;
  } tbl_wr_t;

  function automatic logic signed [QW-1:0] sat32(input logic signed [63:0] v);
    logic signed [QW-1:0] r;
    if (v > 64'(Q_MAX)) begin
      r = Q_MAX;
    end else if (v < 64'(Q_MIN)) begin
      r = Q_MIN;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/tfvw_norm_div.sv
// pipelined restoring divider for footprint normalization, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none

module tfvw_norm_div
  import tfvw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [33:0] num,
  input  wire logic [31:0]        den,
  output logic [CW-1:0]           coord
);

  logic [31:0]           rem_r  [0:NDIV_STEPS];
  logic [NDIV_STEPS-1:0] quo_r  [0:NDIV_STEPS];
  logic                  zero_r [0:NDIV_STEPS];
  logic                  one_r  [0:NDIV_STEPS];

  // den is config derived; the user must keep it steady while items are in flight, this block does not enforce it
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (den == '0) || (num <= 34'sd0);
      one_r[0]  <= (num >= $signed({2'b00, den}));
      rem_r[0]  <= num[31:0];
      quo_r[0]  <= '0;
    end
  end

  for (genvar k = 1; k <= NDIV_STEPS; k++) begin : g_step
    logic [32:0] shl;
    logic        fit;
    assign shl = {rem_r[k-1], 1'b0};
    assign fit = (shl >= {1'b0, den});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= fit ? 32'(shl - {1'b0, den}) : shl[31:0];
        quo_r[k]  <= {quo_r[k-1][NDIV_STEPS-2:0], fit};
        zero_r[k] <= zero_r[k-1];
        one_r[k]  <= one_r[k-1];
      end
    end
  end

  always_comb begin
    if (zero_r[NDIV_STEPS]) begin
      coord = '0;
    end else if (one_r[NDIV_STEPS]) begin
      coord = C_ONE;
    end else begin
      coord = {1'b0, quo_r[NDIV_STEPS]};
    end
  end

endmodule

`default_nettype wire

### design/tfvw_level_div.sv
// pipelined divider for the model level, saturating to 32 bits
`timescale 1ns / 1ps
`default_nettype none

module tfvw_level_div
  import tfvw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [32:0]       mag,
  input  wire logic              neg,
  input  wire logic [30:0]       den,
  output logic signed [QW-1:0]   level
);

  logic [30:0]           rem_r [0:LDIV_STEPS];
  logic [31:0]           low_r [0:LDIV_STEPS];
  logic [LDIV_STEPS-1:0] quo_r [0:LDIV_STEPS];
  logic                  sat_r [0:LDIV_STEPS];
  logic                  neg_r [0:LDIV_STEPS];
  logic [LDIV_STEPS-1:0] q;

  // dividend is mag * 2^16; the top 17 bits decide overflow of a 32 bit quotient
  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0] <= (31'(mag[32:16]) >= den);
      rem_r[0] <= 31'(mag[32:16]);
      low_r[0] <= {mag[15:0], 16'h0000};
      quo_r[0] <= '0;
      neg_r[0] <= neg;
    end
  end

  for (genvar k = 1; k <= LDIV_STEPS; k++) begin : g_step
    logic [31:0] shl;
    logic        fit;
    assign shl = {rem_r[k-1], low_r[k-1][31]};
    assign fit = (shl >= {1'b0, den});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= fit ? 31'(shl - {1'b0, den}) : shl[30:0];
        low_r[k] <= {low_r[k-1][30:0], 1'b0};
        quo_r[k] <= {quo_r[k-1][LDIV_STEPS-2:0], fit};
        sat_r[k] <= sat_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  assign q = quo_r[LDIV_STEPS];

  always_comb begin
    if (sat_r[LDIV_STEPS]) begin
      level = neg_r[LDIV_STEPS] ? Q_MIN : Q_MAX;
    end else if (!neg_r[LDIV_STEPS]) begin
      level = q[31] ? Q_MAX : $signed(q);
    end else begin
      level = (q > 32'h80000000) ? Q_MIN : $signed(32'(-q));
    end
  end

endmodule

`default_nettype wire

### design/tfvw_sample.sv
// height grid and corner tables with the two-step bilinear sampling pipeline
`timescale 1ns / 1ps
`default_nettype none

module tfvw_sample
  import tfvw_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                en,
  input  wire tbl_wr_t             wr,
  input  wire logic [CW-1:0]       cx,
  input  wire logic [CW-1:0]       cy,
  output logic signed [QW-1:0]     terr_z,
  output logic signed [QW-1:0]     terr_lvl
);

  logic signed [QW-1:0] grid_r   [0:GRID_CNT-1];
  logic signed [QW-1:0] corner_r [0:CORNER_COUNT-1];

  always_ff @(posedge clk) begin
    if (en && wr.we) begin
      for (int i = 0; i < GRID_CNT; i++) begin
        if (wr.idx == IDX_W'(i)) grid_r[i] <= wr.data;
      end
      for (int i = 0; i < CORNER_COUNT; i++) begin
        if (wr.idx == IDX_W'(GRID_CNT + i)) corner_r[i] <= wr.data;
      end
    end
  end

  // cell select: s = 2c, cell = min(1, floor(s)), t = s - cell
  logic [CW:0]          sx, sy;
  logic                 ix, iy;
  logic signed [QW-1:0] g00, g01, g10, g11;

  assign sx = {cx, 1'b0};
  assign sy = {cy, 1'b0};
  assign ix = sx[CW] | sx[CW-1];
  assign iy = sy[CW] | sy[CW-1];

  // four cells of the 3x3 grid, row-major
  always_comb begin
    case ({iy, ix})
      2'b00: begin
        g00 = grid_r[0]; g01 = grid_r[1]; g10 = grid_r[3]; g11 = grid_r[4];
      end
      2'b01: begin
        g00 = grid_r[1]; g01 = grid_r[2]; g10 = grid_r[4]; g11 = grid_r[5];
      end
      2'b10: begin
        g00 = grid_r[3]; g01 = grid_r[4]; g10 = grid_r[6]; g11 = grid_r[7];
      end
      default: begin
        g00 = grid_r[4]; g01 = grid_r[5]; g10 = grid_r[7]; g11 = grid_r[8];
      end
    endcase
  end

  // stage 1: gather
  logic signed [QW-1:0] t1_g00_r, t1_g01_r, t1_g10_r, t1_g11_r;
  logic signed [QW-1:0] t1_c0_r, t1_c1_r, t1_c2_r, t1_c3_r;
  logic [CW-1:0]        t1_tx_r, t1_ty_r, t1_cx_r, t1_cy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_g00_r <= g00;
      t1_g01_r <= g01;
      t1_g10_r <= g10;
      t1_g11_r <= g11;
      t1_c0_r  <= corner_r[0];
      t1_c1_r  <= corner_r[1];
      t1_c2_r  <= corner_r[2];
      t1_c3_r  <= corner_r[3];
      t1_tx_r  <= {sx[CW], sx[CW-2:0]};
      t1_ty_r  <= {sy[CW], sy[CW-2:0]};
      t1_cx_r  <= cx;
      t1_cy_r  <= cy;
    end
  end

  // stage 2: horizontal differences
  logic signed [QW:0]   t2_dgt_r, t2_dgb_r, t2_dct_r, t2_dcb_r;
  logic signed [QW-1:0] t2_g00_r, t2_g10_r, t2_c0_r, t2_c3_r;
  logic [CW-1:0]        t2_tx_r, t2_ty_r, t2_cx_r, t2_cy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t2_dgt_r <= 33'(t1_g01_r) - 33'(t1_g00_r);
      t2_dgb_r <= 33'(t1_g11_r) - 33'(t1_g10_r);
      t2_dct_r <= 33'(t1_c1_r) - 33'(t1_c0_r);
      t2_dcb_r <= 33'(t1_c2_r) - 33'(t1_c3_r);
      t2_g00_r <= t1_g00_r;
      t2_g10_r <= t1_g10_r;
      t2_c0_r  <= t1_c0_r;
      t2_c3_r  <= t1_c3_r;
      t2_tx_r  <= t1_tx_r;
      t2_ty_r  <= t1_ty_r;
      t2_cx_r  <= t1_cx_r;
      t2_cy_r  <= t1_cy_r;
    end
  end

  // stage 3: horizontal products
  logic signed [50:0]   t3_pgt_r, t3_pgb_r, t3_pct_r, t3_pcb_r;
  logic signed [QW-1:0] t3_g00_r, t3_g10_r, t3_c0_r, t3_c3_r;
  logic [CW-1:0]        t3_ty_r, t3_cy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t3_pgt_r <= t2_dgt_r * $signed({1'b0, t2_tx_r});
      t3_pgb_r <= t2_dgb_r * $signed({1'b0, t2_tx_r});
      t3_pct_r <= t2_dct_r * $signed({1'b0, t2_cx_r});
      t3_pcb_r <= t2_dcb_r * $signed({1'b0, t2_cx_r});
      t3_g00_r <= t2_g00_r;
      t3_g10_r <= t2_g10_r;
      t3_c0_r  <= t2_c0_r;
      t3_c3_r  <= t2_c3_r;
      t3_ty_r  <= t2_ty_r;
      t3_cy_r  <= t2_cy_r;
    end
  end

  // stage 4: row results; floor of the product by dropping 16 bits
  logic signed [34:0]   ga_s, gb_s, ca_s, cb_s;
  logic signed [QW-1:0] t4_ga_r, t4_gb_r, t4_ca_r, t4_cb_r;
  logic [CW-1:0]        t4_ty_r, t4_cy_r;

  assign ga_s = $signed(t3_pgt_r[50:16]) + 35'(t3_g00_r);
  assign gb_s = $signed(t3_pgb_r[50:16]) + 35'(t3_g10_r);
  assign ca_s = $signed(t3_pct_r[50:16]) + 35'(t3_c0_r);
  assign cb_s = $signed(t3_pcb_r[50:16]) + 35'(t3_c3_r);

  always_ff @(posedge clk) begin
    if (en) begin
      t4_ga_r <= ga_s[QW-1:0];
      t4_gb_r <= gb_s[QW-1:0];
      t4_ca_r <= ca_s[QW-1:0];
      t4_cb_r <= cb_s[QW-1:0];
      t4_ty_r <= t3_ty_r;
      t4_cy_r <= t3_cy_r;
    end
  end

  // stage 5: vertical differences
  logic signed [QW:0]   t5_dg_r, t5_dc_r;
  logic signed [QW-1:0] t5_ga_r, t5_ca_r;
  logic [CW-1:0]        t5_ty_r, t5_cy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t5_dg_r <= 33'(t4_gb_r) - 33'(t4_ga_r);
      t5_dc_r <= 33'(t4_cb_r) - 33'(t4_ca_r);
      t5_ga_r <= t4_ga_r;
      t5_ca_r <= t4_ca_r;
      t5_ty_r <= t4_ty_r;
      t5_cy_r <= t4_cy_r;
    end
  end

  // stage 6: vertical products
  logic signed [50:0]   t6_pg_r, t6_pc_r;
  logic signed [QW-1:0] t6_ga_r, t6_ca_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t6_pg_r <= t5_dg_r * $signed({1'b0, t5_ty_r});
      t6_pc_r <= t5_dc_r * $signed({1'b0, t5_cy_r});
      t6_ga_r <= t5_ga_r;
      t6_ca_r <= t5_ca_r;
    end
  end

  // stage 7: final lerp
  logic signed [34:0] tz_s, tl_s;

  assign tz_s = $signed(t6_pg_r[50:16]) + 35'(t6_ga_r);
  assign tl_s = $signed(t6_pc_r[50:16]) + 35'(t6_ca_r);

  always_ff @(posedge clk) begin
    if (en) begin
      terr_z   <= tz_s[QW-1:0];
      terr_lvl <= tl_s[QW-1:0];
    end
  end

endmodule

`default_nettype wire

### design/terrain_fit_vertex_warp_core.sv
// Terrain vertex warp: fits one model vertex per cycle, while the pipeline is not held, onto a 3x3 height grid.
//
// Input channel (in_valid / in_stall): a transfer is either a table load
// (req_type 1, table_index 0-8 grid row-major, 9-12 corner levels, other
// indices dropped) or a vertex (req_type 0). Loads produce no result.
// Result channel (out_valid / out_stall): one vert_x, vert_y, vert_z per vertex,
// in order. Config port (cfg_valid / cfg_ready, always ready) writes registers
// 0-7 and must only be used while no vertex is in flight.
// The block accepts one item per cycle while the pipeline is not held; a 16-stage
// normalize divider feeding the sampling stages runs beside a 32-stage level
// divider, followed by output stages.
// Tables are written at the pipeline stage where vertices read them, so a
// vertex sees exactly the loads that came before it.
// Reset clears all valid bits and restores register defaults; table contents
// are undefined until loaded. When the receiver stalls a waiting result, the
// whole pipeline holds and in_stall is raised in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module terrain_fit_vertex_warp_core
  import tfvw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_req_type,
  input  wire logic [IDX_W-1:0]      in_table_index,
  input  wire logic signed [QW-1:0]  in_table_value,
  input  wire logic signed [QW-1:0]  in_rot_x,
  input  wire logic signed [QW-1:0]  in_rot_y,
  input  wire logic signed [QW-1:0]  in_local_z,
  input  wire logic signed [QW-1:0]  in_offset_x,
  input  wire logic signed [QW-1:0]  in_offset_y,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [QW-1:0]       out_vert_x,
  output logic signed [QW-1:0]       out_vert_y,
  output logic signed [QW-1:0]       out_vert_z,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [QW-1:0]         cfg_data
);

  // configuration registers
  logic signed [QW-1:0] foot_min_x_r, foot_max_x_r, foot_min_y_r, foot_max_y_r;
  logic signed [QW-1:0] model_span_r, terrain_span_r, bound_min_z_r;
  logic [30:0]          cell_size_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      foot_min_x_r   <= '0;
      foot_max_x_r   <= 32'sd65536;
      foot_min_y_r   <= '0;
      foot_max_y_r   <= 32'sd65536;
      model_span_r   <= 32'sd65536;
      terrain_span_r <= 32'sd65536;
      cell_size_r    <= 31'd65536;
      bound_min_z_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FOOT_MIN_X:   foot_min_x_r   <= cfg_data;
        CFG_FOOT_MAX_X:   foot_max_x_r   <= cfg_data;
        CFG_FOOT_MIN_Y:   foot_min_y_r   <= cfg_data;
        CFG_FOOT_MAX_Y:   foot_max_y_r   <= cfg_data;
        CFG_MODEL_SPAN:   model_span_r   <= cfg_data;
        CFG_TERRAIN_SPAN: terrain_span_r <= cfg_data;
        CFG_CELL_SIZE:    cell_size_r    <= cfg_data[30:0];
        CFG_BOUND_MIN_Z:  bound_min_z_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [ST_OUT:0] vx_r;
  logic [ST_CX:0]  ld_r;

  // global advance: everything moves unless a finished result is held
  logic en;
  assign en       = !vx_r[ST_OUT] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r <= '0;
      ld_r <= '0;
    end else if (en) begin
      vx_r <= {vx_r[ST_OUT-1:0], in_valid && (in_req_type == REQ_VERTEX)};
      ld_r <= {ld_r[ST_CX-1:0], in_valid && (in_req_type == REQ_LOAD)};
    end
  end

  // payload pipeline
  logic [IDX_W-1:0]     idx_d  [0:ST_CX];
  logic [QW-1:0]        val_d  [0:ST_CX];
  logic signed [QW-1:0] offx_d [0:ST_ML];
  logic signed [QW-1:0] offy_d [0:ST_ML];
  logic signed [QW-1:0] rot_x_r, rot_y_r, local_z_r;

  always_ff @(posedge clk) begin
    if (en) begin
      idx_d[0]  <= in_table_index;
      val_d[0]  <= in_table_value;
      offx_d[0] <= in_offset_x;
      offy_d[0] <= in_offset_y;
      rot_x_r   <= in_rot_x;
      rot_y_r   <= in_rot_y;
      local_z_r <= in_local_z;
      for (int k = 1; k <= ST_CX; k++) begin
        idx_d[k] <= idx_d[k-1];
        val_d[k] <= val_d[k-1];
      end
      for (int k = 1; k <= ST_ML; k++) begin
        offx_d[k] <= offx_d[k-1];
        offy_d[k] <= offy_d[k-1];
      end
    end
  end

  // stage 1: offsets from the footprint, oriented so the divisor is non-negative
  logic signed [QW:0] nx_p, nx_n, dx_p, dx_n, ny_p, ny_n, dy_p, dy_n, dz_p, dz_n;
  logic [31:0]        den_x, den_y;
  logic signed [33:0] num_x_r, num_y_r;
  logic [32:0]        mag_r;
  logic               neg_r;

  assign nx_p = 33'(rot_x_r) - 33'(foot_min_x_r);
  assign nx_n = 33'(foot_min_x_r) - 33'(rot_x_r);
  assign dx_p = 33'(foot_max_x_r) - 33'(foot_min_x_r);
  assign dx_n = 33'(foot_min_x_r) - 33'(foot_max_x_r);
  assign ny_p = 33'(rot_y_r) - 33'(foot_min_y_r);
  assign ny_n = 33'(foot_min_y_r) - 33'(rot_y_r);
  assign dy_p = 33'(foot_max_y_r) - 33'(foot_min_y_r);
  assign dy_n = 33'(foot_min_y_r) - 33'(foot_max_y_r);
  assign dz_p = 33'(local_z_r) - 33'(bound_min_z_r);
  assign dz_n = 33'(bound_min_z_r) - 33'(local_z_r);

  assign den_x = dx_p[QW] ? dx_n[31:0] : dx_p[31:0];
  assign den_y = dy_p[QW] ? dy_n[31:0] : dy_p[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      num_x_r <= dx_p[QW] ? 34'(nx_n) : 34'(nx_p);
      num_y_r <= dy_p[QW] ? 34'(ny_n) : 34'(ny_p);
      mag_r   <= dz_p[QW] ? dz_n : dz_p;
      neg_r   <= dz_p[QW];
    end
  end

  logic [CW-1:0]        cx, cy;
  logic signed [QW-1:0] model_lvl;
  logic signed [QW-1:0] terr_z, terr_lvl;
  tbl_wr_t              tbl_wr;

  tfvw_norm_div u_div_x (
    .clk   (clk),
    .en    (en),
    .num   (num_x_r),
    .den   (den_x),
    .coord (cx)
  );

  tfvw_norm_div u_div_y (
    .clk   (clk),
    .en    (en),
    .num   (num_y_r),
    .den   (den_y),
    .coord (cy)
  );

  tfvw_level_div u_div_lvl (
    .clk   (clk),
    .en    (en),
    .mag   (mag_r),
    .neg   (neg_r),
    .den   (model_span_r[30:0]),
    .level (model_lvl)
  );

  assign tbl_wr.we   = ld_r[ST_CX];
  assign tbl_wr.idx  = idx_d[ST_CX];
  assign tbl_wr.data = val_d[ST_CX];

  tfvw_sample u_sample (
    .clk      (clk),
    .en       (en),
    .wr       (tbl_wr),
    .cx       (cx),
    .cy       (cy),
    .terr_z   (terr_z),
    .terr_lvl (terr_lvl)
  );

  // align sampled and normalized values with the level divider output
  logic [CW-1:0]        cx_d [ST_CX+1:ST_ML];
  logic [CW-1:0]        cy_d [ST_CX+1:ST_ML];
  logic signed [QW-1:0] tz_d [ST_TZ+1:ST_ML];
  logic signed [QW-1:0] tl_d [ST_TZ+1:ST_ML];

  always_ff @(posedge clk) begin
    if (en) begin
      cx_d[ST_CX+1] <= cx;
      cy_d[ST_CX+1] <= cy;
      for (int k = ST_CX + 2; k <= ST_ML; k++) begin
        cx_d[k] <= cx_d[k-1];
        cy_d[k] <= cy_d[k-1];
      end
      tz_d[ST_TZ+1] <= terr_z;
      tl_d[ST_TZ+1] <= terr_lvl;
      for (int k = ST_TZ + 2; k <= ST_ML; k++) begin
        tz_d[k] <= tz_d[k-1];
        tl_d[k] <= tl_d[k-1];
      end
    end
  end

  // final stage 1: differences; a small model span falls back to the terrain level
  logic                 use_model;
  logic signed [QW:0]   f1_dl_r;
  logic signed [CW:0]   f1_cxm_r, f1_cym_r;
  logic signed [QW-1:0] f1_tz_r, f1_offx_r, f1_offy_r;

  assign use_model = (model_span_r > EPS_RAW);

  always_ff @(posedge clk) begin
    if (en) begin
      f1_dl_r   <= use_model ? 33'(model_lvl) - 33'(tl_d[ST_ML]) : '0;
      f1_cxm_r  <= $signed({1'b0, cx_d[ST_ML]}) - 18'sd32768;
      f1_cym_r  <= $signed({1'b0, cy_d[ST_ML]}) - 18'sd32768;
      f1_tz_r   <= tz_d[ST_ML];
      f1_offx_r <= offx_d[ST_ML];
      f1_offy_r <= offy_d[ST_ML];
    end
  end

  // final stage 2: products
  logic signed [64:0]   f2_pz_r;
  logic signed [50:0]   f2_px_r, f2_py_r;
  logic signed [QW-1:0] f2_tz_r, f2_offx_r, f2_offy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      f2_pz_r   <= f1_dl_r * terrain_span_r;
      f2_px_r   <= f1_cxm_r * $signed({1'b0, cell_size_r, 1'b0});
      f2_py_r   <= f1_cym_r * $signed({1'b0, cell_size_r, 1'b0});
      f2_tz_r   <= f1_tz_r;
      f2_offx_r <= f1_offx_r;
      f2_offy_r <= f1_offy_r;
    end
  end

  // final stage 3: floor, add and saturate into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_vert_z <= sat32(64'(f2_tz_r) + 64'($signed(f2_pz_r[64:16])));
      out_vert_x <= sat32(64'(f2_offx_r) + 64'($signed(f2_px_r[50:16])));
      out_vert_y <= sat32(64'(f2_offy_r) + 64'($signed(f2_py_r[50:16])));
    end
  end

  assign out_valid = vx_r[ST_OUT];

  a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_vertex_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vx_r[ST_OUT-1]) |=> out_valid)
    else $error("vertex lost before output register");

  a_hold_keeps_items: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(vx_r) && $stable(ld_r)))
    else $error("pipeline valid bits moved during stall");

endmodule

`default_nettype wire

### bench/terrain_fit_checker.sv
// channel monitor, height-fit predictor and result comparison for the vertex warp block
`timescale 1ns / 1ps

module terrain_fit_checker
  import tfvw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_req_type,
  input  logic [3:0]           in_table_index,
  input  logic signed [31:0]   in_table_value,
  input  logic signed [31:0]   in_rot_x,
  input  logic signed [31:0]   in_rot_y,
  input  logic signed [31:0]   in_local_z,
  input  logic signed [31:0]   in_offset_x,
  input  logic signed [31:0]   in_offset_y,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic signed [31:0]   out_vert_x,
  input  logic signed [31:0]   out_vert_y,
  input  logic signed [31:0]   out_vert_z,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   mismatch_count,
  output int                   vertices_pending
);

  typedef struct {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } fitted_vertex_t;

  localparam longint ONE  = 65536;
  localparam longint HALF = 32768;

  fitted_vertex_t fitted_q[$];

  longint grid_h[9];
  longint corner_h[4];
  longint fmin_x, fmax_x, fmin_y, fmax_y;
  longint mspan, tspan, cell_sz, bmin_z;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return a + (((b - a) * t) >>> 16);
  endfunction

  function automatic longint unit_coord(longint p, longint lo, longint hi);
    longint num;
    longint den;
    num = p - lo;
    den = hi - lo;
    if (den == 0) return 0;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num <= 0) return 0;
    if (num >= den) return ONE;
    return (num * ONE) / den;
  endfunction

  function automatic fitted_vertex_t fit_vertex(longint rx, longint ry, longint lz,
                                                longint ox, longint oy);
    fitted_vertex_t r;
    longint cx, cy, sx, sy, ix, iy, tx, ty, a, b, tz, tl, ml;
    cx = unit_coord(rx, fmin_x, fmax_x);
    cy = unit_coord(ry, fmin_y, fmax_y);
    sx = cx * 2;
    sy = cy * 2;
    ix = (sx >>> 16) > 1 ? 1 : (sx >>> 16);
    iy = (sy >>> 16) > 1 ? 1 : (sy >>> 16);
    tx = sx - ix * ONE;
    ty = sy - iy * ONE;
    a = blend(grid_h[ix + iy * 3], grid_h[ix + 1 + iy * 3], tx);
    b = blend(grid_h[ix + (iy + 1) * 3], grid_h[ix + 1 + (iy + 1) * 3], tx);
    tz = blend(a, b, ty);
    a = blend(corner_h[0], corner_h[1], cx);
    b = blend(corner_h[3], corner_h[2], cx);
    tl = blend(a, b, cy);
    // flat model: fall back to the terrain level so only tz remains
    if (mspan > 65) ml = clip32(((lz - bmin_z) * ONE) / mspan);
    else ml = tl;
    r.vz = 32'(clip32(tz + (((ml - tl) * tspan) >>> 16)));
    r.vx = 32'(clip32(ox + (((cx - HALF) * 2 * cell_sz) >>> 16)));
    r.vy = 32'(clip32(oy + (((cy - HALF) * 2 * cell_sz) >>> 16)));
    return r;
  endfunction

  assign vertices_pending = fitted_q.size();

  always @(posedge clk) begin
    fitted_vertex_t e;
    if (!rst_n) begin
      fmin_x <= 0; fmax_x <= ONE; fmin_y <= 0; fmax_y <= ONE;
      mspan <= ONE; tspan <= ONE; cell_sz <= ONE; bmin_z <= 0;
      mismatch_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (fitted_q.size() == 0) begin
          $display("%0t unexpected result x %h y %h z %h", $time,
                   out_vert_x, out_vert_y, out_vert_z);
          mismatch_count <= mismatch_count + 1;
        end else begin
          e = fitted_q.pop_front();
          if (e.vx !== out_vert_x || e.vy !== out_vert_y || e.vz !== out_vert_z) begin
            $display("%0t vertex mismatch expected x %h y %h z %h actual x %h y %h z %h",
                     $time, e.vx, e.vy, e.vz, out_vert_x, out_vert_y, out_vert_z);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_req_type == REQ_LOAD) begin
          if (in_table_index < 9) grid_h[in_table_index] = longint'(in_table_value);
          else if (in_table_index < 13) corner_h[in_table_index - 9] = longint'(in_table_value);
        end else begin
          fitted_q.push_back(fit_vertex(longint'(in_rot_x), longint'(in_rot_y),
                                        longint'(in_local_z), longint'(in_offset_x),
                                        longint'(in_offset_y)));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FOOT_MIN_X:   fmin_x <= longint'($signed(cfg_data));
          CFG_FOOT_MAX_X:   fmax_x <= longint'($signed(cfg_data));
          CFG_FOOT_MIN_Y:   fmin_y <= longint'($signed(cfg_data));
          CFG_FOOT_MAX_Y:   fmax_y <= longint'($signed(cfg_data));
          CFG_MODEL_SPAN:   mspan <= longint'($signed(cfg_data));
          CFG_TERRAIN_SPAN: tspan <= longint'($signed(cfg_data));
          CFG_CELL_SIZE:    cell_sz <= longint'({33'd0, cfg_data[30:0]});
          CFG_BOUND_MIN_Z:  bmin_z <= longint'($signed(cfg_data));
          default: ;
        endcase
      end
    end
  end

endmodule

### bench/tb_terrain_fit_vertex_warp_core.sv
// stimulus, configuration phases and verdict for the terrain vertex warp block
`timescale 1ns / 1ps

module tb_terrain_fit_vertex_warp_core;
  import tfvw_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int DRAIN_CYCLES = 45;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_req_type = REQ_VERTEX;
  logic [3:0] in_table_index = '0;
  logic signed [31:0] in_table_value = '0;
  logic signed [31:0] in_rot_x = '0;
  logic signed [31:0] in_rot_y = '0;
  logic signed [31:0] in_local_z = '0;
  logic signed [31:0] in_offset_x = '0;
  logic signed [31:0] in_offset_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_vert_x, out_vert_y, out_vert_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int mismatch_count;
  int vertices_pending;
  int cycle_count = 0;
  bit calm_sender = 1'b0;
  bit long_hold_go = 1'b0;
  bit long_hold_done = 1'b0;

  // stimulus copy of the footprint and depth base
  longint lo_x = 0, hi_x = 65536, lo_y = 0, hi_y = 65536, base_z = 0;

  terrain_fit_vertex_warp_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_table_index(in_table_index), .in_table_value(in_table_value),
    .in_rot_x(in_rot_x), .in_rot_y(in_rot_y), .in_local_z(in_local_z),
    .in_offset_x(in_offset_x), .in_offset_y(in_offset_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_vert_x(out_vert_x), .out_vert_y(out_vert_y), .out_vert_z(out_vert_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  terrain_fit_checker u_fit_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_table_index(in_table_index), .in_table_value(in_table_value),
    .in_rot_x(in_rot_x), .in_rot_y(in_rot_y), .in_local_z(in_local_z),
    .in_offset_x(in_offset_x), .in_offset_y(in_offset_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_vert_x(out_vert_x), .out_vert_y(out_vert_y), .out_vert_z(out_vert_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .vertices_pending(vertices_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: calm and busy stretches, plus one long hold-off to back up the pipe
  initial begin
    int r;
    int hold;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold_go && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold = 400;
        while (hold > 0) begin
          out_stall <= 1'b1;
          @(posedge clk);
          hold--;
        end
      end
      r = $urandom_range(0, 99);
      if ((cycle_count / 700) % 3 == 0) out_stall <= 1'b0;
      else if (r < 55) out_stall <= 1'b0;
      else if (r < 95) out_stall <= 1'b1;
      else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(5, 30)) @(posedge clk);
      end
    end
  end

  function automatic longint pick_between(longint lo, longint hi);
    longint span;
    if (hi <= lo) return longint'($signed($urandom));
    span = hi - lo + 1;
    return lo + longint'({$urandom, $urandom} & 64'h7fffffffffffffff) % span;
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h7fffffff;
    if (r == 1) return 32'h80000000;
    if (r < 6) return 32'($signed($urandom_range(0, 'h7ffff)) - 'sh40000);
    return $urandom;
  endfunction

  task automatic send_item(logic req, logic [3:0] idx, logic [31:0] val,
                           logic [31:0] rx, logic [31:0] ry, logic [31:0] lz,
                           logic [31:0] ox, logic [31:0] oy);
    int gap;
    in_valid <= 1'b1;
    in_req_type <= req;
    in_table_index <= idx;
    in_table_value <= val;
    in_rot_x <= rx;
    in_rot_y <= ry;
    in_local_z <= lz;
    in_offset_x <= ox;
    in_offset_y <= oy;
    do @(posedge clk); while (in_stall);
    gap = $urandom_range(0, 99);
    if (calm_sender || gap < 60) gap = 0;
    else if (gap < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_FOOT_MIN_X:  lo_x = longint'($signed(val));
      CFG_FOOT_MAX_X:  hi_x = longint'($signed(val));
      CFG_FOOT_MIN_Y:  lo_y = longint'($signed(val));
      CFG_FOOT_MAX_Y:  hi_y = longint'($signed(val));
      CFG_BOUND_MIN_Z: base_z = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (vertices_pending != 0) @(posedge clk);
    // loads may still be in flight with nothing expected
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_vertex(logic [31:0] rx, logic [31:0] ry, logic [31:0] lz,
                             logic [31:0] ox, logic [31:0] oy);
    send_item(REQ_VERTEX, 4'($urandom), $urandom, rx, ry, lz, ox, oy);
  endtask

  task automatic send_random();
    longint rx, ry, lz;
    if ($urandom_range(0, 99) < 15) begin
      send_item(REQ_LOAD, 4'($urandom_range(0, 15)), pick_word(), $urandom, $urandom,
                $urandom, $urandom, $urandom);
    end else begin
      rx = ($urandom_range(0, 9) < 7) ? pick_between(lo_x, hi_x) : longint'($urandom);
      ry = ($urandom_range(0, 9) < 7) ? pick_between(lo_y, hi_y) : longint'($urandom);
      lz = $urandom_range(0, 1) ? base_z + pick_between(-'sh40000, 'sh40000)
                                : longint'($urandom);
      send_vertex(32'(rx), 32'(ry), 32'(lz), pick_word(), pick_word());
    end
  endtask

  initial begin
    longint a, b;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every table entry is loaded before the first vertex
    for (int i = 0; i < 13; i++) begin
      send_item(REQ_LOAD, 4'(i), (i % 3 == 0) ? 32'h7fffffff : (i % 3 == 1) ? 32'h80000000
                : 32'(i * 'h18000), $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    // out-of-range loads are dropped
    send_item(REQ_LOAD, 4'd13, 32'h0, 0, 0, 0, 0, 0);
    send_item(REQ_LOAD, 4'd15, 32'hffffffff, 0, 0, 0, 0, 0);
    send_vertex(32'h0, 32'h0, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_vertex(32'h10000, 32'h10000, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_vertex(32'h8000, 32'h8000, 32'h8000, 32'h0, 32'h0);
    send_vertex(32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff, 32'h1);
    send_vertex(32'h7fffffff, 32'h80000000, 32'h10000, 32'h0, 32'h0);
    send_vertex(32'h4000, 32'hc000, 32'hffff0000, 32'h12345, 32'hfff00000);
    send_vertex(32'hffffffff, 32'h10001, 32'h1, 32'h0, 32'h0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      calm_sender = (p % 3 == 1);
      case (p)
        0: begin
          write_reg(CFG_FOOT_MIN_X, 32'h80000000);
          write_reg(CFG_FOOT_MAX_X, 32'h7fffffff);
          write_reg(CFG_FOOT_MIN_Y, 32'h80000000);
          write_reg(CFG_FOOT_MAX_Y, 32'h7fffffff);
          write_reg(CFG_MODEL_SPAN, 32'd65);
          write_reg(CFG_TERRAIN_SPAN, 32'h7fffffff);
          write_reg(CFG_CELL_SIZE, 32'h7fffffff);
          write_reg(CFG_BOUND_MIN_Z, 32'h80000000);
        end
        1: begin
          // degenerate footprint collapses both coordinates to zero
          write_reg(CFG_FOOT_MIN_X, 32'h30000);
          write_reg(CFG_FOOT_MAX_X, 32'h30000);
          write_reg(CFG_FOOT_MIN_Y, 32'hfffe0000);
          write_reg(CFG_FOOT_MAX_Y, 32'hfffe0000);
          write_reg(CFG_MODEL_SPAN, 32'd66);
          write_reg(CFG_TERRAIN_SPAN, 32'h80000000);
          write_reg(CFG_CELL_SIZE, 32'h0);
          write_reg(CFG_BOUND_MIN_Z, 32'h7fffffff);
        end
        2: begin
          // reversed footprint and a negative model span
          write_reg(CFG_FOOT_MIN_X, 32'h50000);
          write_reg(CFG_FOOT_MAX_X, 32'hfffb0000);
          write_reg(CFG_FOOT_MIN_Y, 32'h7fffffff);
          write_reg(CFG_FOOT_MAX_Y, 32'h80000000);
          write_reg(CFG_MODEL_SPAN, 32'hffff0000);
          write_reg(CFG_TERRAIN_SPAN, 32'h0);
          write_reg(CFG_CELL_SIZE, 32'hffffffff);
          write_reg(CFG_BOUND_MIN_Z, 32'h0);
        end
        default: begin
          a = pick_between(-'sh1000000, 'sh1000000);
          b = a + pick_between(1, 'sh800000);
          write_reg(CFG_FOOT_MIN_X, 32'(a));
          write_reg(CFG_FOOT_MAX_X, 32'(b));
          a = pick_between(-'sh1000000, 'sh1000000);
          b = a + pick_between(1, 'sh800000);
          write_reg(CFG_FOOT_MIN_Y, 32'(a));
          write_reg(CFG_FOOT_MAX_Y, 32'(b));
          write_reg(CFG_MODEL_SPAN, $urandom_range(0, 3) == 0 ? 32'h80000000
                                    : 32'($urandom_range(1, 'h200000)));
          write_reg(CFG_TERRAIN_SPAN, pick_word());
          write_reg(CFG_CELL_SIZE, $urandom);
          write_reg(CFG_BOUND_MIN_Z, pick_word());
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // receiver holds off while the sender keeps offering back to back
        if (p == 4 && n == 20) long_hold_go = 1'b1;
        send_random();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (vertices_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && vertices_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
